// ----- hw/rtl/pms_pkg.sv -----
// Shared constants and codes for the PWM melody sequencer.
// Used by the top level of the block; no dependencies of its own.
`timescale 1ns / 1ps

package pms_pkg;

    // Field widths of the command, result and configuration ports.
    localparam int CMD_W    = 2;
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int PERIOD_W = 16;
    localparam int DUTY_W   = 15;
    localparam int MODE_W   = 2;
    localparam int VOL_W    = 6;

    // A melody entry holds the frequency above the duration.
    localparam int ENTRY_W  = FREQ_W + DUR_W;

    // The period times the volume, before the percentage division.
    localparam int PROD_W   = PERIOD_W + VOL_W;

    // Divisor for the percentage step.
    localparam int PCT_W    = 7;
    localparam logic [PCT_W-1:0] PERCENT = 7'd100;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
    localparam logic [DUR_W-1:0]    GAP_TICKS  = 16'd5;
    localparam logic [VOL_W-1:0]    VOL_MAX    = 6'd50;
    localparam logic [VOL_W-1:0]    VOL_RESET  = 6'd50;

    // Defaults for the top-level parameters.
    localparam int MAX_NOTES_DEF      = 64;
    localparam int TIMER_CLOCK_HZ_DEF = 7200000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_TONE  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_START = 2'd3
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PLAYING = 2'd1,
        MODE_GAP     = 2'd2
    } t_mode;

endpackage

// ----- hw/rtl/pms_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the melody store; no package dependencies.
`timescale 1ns / 1ps

module pms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/pms_serial_div.sv -----
// Bit-serial restoring divider: one quotient bit per clock, MSB first.
// Used by the sequencer for the period and for the duty percentage.
`timescale 1ns / 1ps

module pms_serial_div #(
    parameter int DVD_W = 23,
    parameter int DSR_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DSR_W-1:0] r_dsr;
    logic [DSR_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_dvd <= r_dvd << 1;
                r_rem <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], fits};
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/pwm_melody_sequencer.sv -----
// Top level of the PWM melody sequencer.
// Depends on pms_pkg, pms_ram and pms_serial_div.
`timescale 1ns / 1ps

// Every transaction on the input channel yields exactly one result: the PWM
// period, compare value, running flag and play mode as they stand after the
// command. A tick that only counts down, a melody entry write and a melody
// start go from acceptance straight to S_EMIT, where the result is registered;
// a tick that fetches a rest passes S_READ first. A single tone passes S_DIV1,
// S_MUL and S_DIV2 before S_EMIT, and a tick that fetches a sounding melody
// note passes S_READ first for the store read: one serial divider forms the
// period one bit per cycle, a shift-add loop scales it by the volume, and the
// same divider then takes the percentage. The next transaction can be
// accepted in the cycle after a result is registered, even while that result
// still waits at the output; its own result is then held back until the
// waiting one has been taken. The volume register may be written only while
// the block is idle.
module pwm_melody_sequencer #(
    parameter int MAX_NOTES      = pms_pkg::MAX_NOTES_DEF,
    parameter int TIMER_CLOCK_HZ = pms_pkg::TIMER_CLOCK_HZ_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_we,
    input  logic [pms_pkg::VOL_W-1:0]    i_cfg_wdata,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pms_pkg::CMD_W-1:0]    i_command,
    input  logic [pms_pkg::FREQ_W-1:0]   i_freq_hz,
    input  logic [pms_pkg::DUR_W-1:0]    i_note_ms,
    input  logic [pms_pkg::SLOT_W-1:0]   i_note_slot,
    input  logic [pms_pkg::COUNT_W-1:0]  i_note_count,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pms_pkg::PERIOD_W-1:0] o_reload_value,
    output logic [pms_pkg::DUTY_W-1:0]   o_compare_value,
    output logic                         o_pwm_running,
    output logic [pms_pkg::MODE_W-1:0]   o_play_mode
);

    localparam int ADDR_W  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int LIM_B   = $clog2(MAX_NOTES + 1);
    localparam int LIM_W   = (LIM_B > pms_pkg::COUNT_W) ? LIM_B : pms_pkg::COUNT_W;
    localparam int CLK_W   = $clog2(TIMER_CLOCK_HZ + 1);
    localparam int DVD_W   = (CLK_W > pms_pkg::PROD_W) ? CLK_W : pms_pkg::PROD_W;
    localparam int MCNT_W  = $clog2(pms_pkg::VOL_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV1,
        S_MUL,
        S_DIV2,
        S_EMIT
    } t_state;

    t_state                         r_state;

    logic [pms_pkg::VOL_W-1:0]      r_volume;
    pms_pkg::t_mode                 r_mode;
    logic [pms_pkg::DUR_W-1:0]      r_countdown;
    logic [pms_pkg::PERIOD_W-1:0]   r_period;
    logic [pms_pkg::DUTY_W-1:0]     r_duty;
    logic                           r_running;
    logic [pms_pkg::COUNT_W-1:0]    r_length;
    logic [pms_pkg::COUNT_W-1:0]    r_position;
    logic                           r_loaded;

    logic                           r_div_go;
    logic [DVD_W-1:0]               r_div_dvd;
    logic [pms_pkg::FREQ_W-1:0]     r_div_dsr;

    logic [pms_pkg::PROD_W-1:0]     r_acc;
    logic [pms_pkg::PROD_W-1:0]     r_mcand;
    logic [pms_pkg::VOL_W-1:0]      r_mplier;
    logic [MCNT_W-1:0]              r_mul_cnt;

    logic                           r_out_valid;
    logic [pms_pkg::PERIOD_W-1:0]   r_out_period;
    logic [pms_pkg::DUTY_W-1:0]     r_out_duty;
    logic                           r_out_running;
    logic [pms_pkg::MODE_W-1:0]     r_out_mode;

    logic                           accept;
    logic                           store_we;
    logic [pms_pkg::ENTRY_W-1:0]    entry;
    logic [pms_pkg::FREQ_W-1:0]     entry_freq;
    logic [pms_pkg::DUR_W-1:0]      entry_dur;
    logic                           div_done;
    logic [DVD_W-1:0]               div_quo;
    logic [DVD_W-1:0]               quo_m1;
    logic [pms_pkg::PERIOD_W-1:0]   n_period;
    logic [pms_pkg::VOL_W-1:0]      vol_eff;
    logic [LIM_W-1:0]               count_ext;
    logic [LIM_W-1:0]               note_lim;
    logic [pms_pkg::COUNT_W-1:0]    n_length;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign store_we = accept && (pms_pkg::t_cmd'(i_command) == pms_pkg::CMD_WRITE)
                      && (LIM_W'(i_note_slot) < LIM_W'(MAX_NOTES));

    pms_ram #(
        .WIDTH (pms_pkg::ENTRY_W),
        .DEPTH (MAX_NOTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (ADDR_W'(i_note_slot)),
        .i_wdata ({i_freq_hz, i_note_ms}),
        .i_raddr (ADDR_W'(r_position)),
        .o_rdata (entry)
    );

    pms_serial_div #(
        .DVD_W (DVD_W),
        .DSR_W (pms_pkg::FREQ_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dsr),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        entry_freq = entry[pms_pkg::ENTRY_W-1:pms_pkg::DUR_W];
        entry_dur  = entry[pms_pkg::DUR_W-1:0];

        // A quotient of zero (frequency above the timer clock) gives period zero.
        quo_m1 = div_quo - 1'b1;
        if (div_quo == '0) begin
            n_period = '0;
        end else if (quo_m1 > DVD_W'(pms_pkg::PERIOD_MAX)) begin
            n_period = pms_pkg::PERIOD_MAX;
        end else begin
            n_period = quo_m1[pms_pkg::PERIOD_W-1:0];
        end

        vol_eff = (r_volume > pms_pkg::VOL_MAX) ? pms_pkg::VOL_MAX : r_volume;

        count_ext = LIM_W'(i_note_count);
        note_lim  = LIM_W'(MAX_NOTES);
        n_length  = pms_pkg::COUNT_W'((count_ext > note_lim) ? note_lim : count_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_volume      <= pms_pkg::VOL_RESET;
            r_mode        <= pms_pkg::MODE_IDLE;
            r_countdown   <= '0;
            r_period      <= '0;
            r_duty        <= '0;
            r_running     <= 1'b0;
            r_length      <= '0;
            r_position    <= '0;
            r_loaded      <= 1'b0;
            r_div_go      <= 1'b0;
            r_mul_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_div_go <= 1'b0;

            if (i_cfg_we) begin
                r_volume <= i_cfg_wdata;
            end

            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EMIT;
                        unique case (pms_pkg::t_cmd'(i_command))
                            pms_pkg::CMD_TICK: begin
                                if (r_countdown != '0) begin
                                    r_countdown <= r_countdown - 1'b1;
                                end else if (r_mode == pms_pkg::MODE_PLAYING) begin
                                    r_duty      <= '0;
                                    r_countdown <= pms_pkg::GAP_TICKS;
                                    r_mode      <= pms_pkg::MODE_GAP;
                                end else if (!r_loaded || r_position >= r_length) begin
                                    r_running <= 1'b0;
                                    r_mode    <= pms_pkg::MODE_IDLE;
                                end else begin
                                    // The store entry at the current position is
                                    // read out in the next cycle.
                                    r_state <= S_READ;
                                end
                            end
                            pms_pkg::CMD_TONE: begin
                                if (i_freq_hz != '0) begin
                                    r_loaded    <= 1'b0;
                                    r_length    <= '0;
                                    r_running   <= 1'b1;
                                    r_countdown <= i_note_ms;
                                    r_mode      <= pms_pkg::MODE_PLAYING;
                                    r_div_go    <= 1'b1;
                                    r_div_dvd   <= DVD_W'(TIMER_CLOCK_HZ);
                                    r_div_dsr   <= i_freq_hz;
                                    r_state     <= S_DIV1;
                                end
                            end
                            pms_pkg::CMD_WRITE: begin
                                // The store write itself happens on this edge, if the slot lies within the store.
                            end
                            pms_pkg::CMD_START: begin
                                r_running   <= 1'b0;
                                r_loaded    <= 1'b1;
                                r_length    <= n_length;
                                r_position  <= '0;
                                r_countdown <= '0;
                                r_mode      <= pms_pkg::MODE_IDLE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_READ: begin
                    r_countdown <= entry_dur;
                    r_position  <= r_position + 1'b1;
                    if (entry_freq != '0) begin
                        r_mode    <= pms_pkg::MODE_PLAYING;
                        r_running <= 1'b1;
                        r_div_go  <= 1'b1;
                        r_div_dvd <= DVD_W'(TIMER_CLOCK_HZ);
                        r_div_dsr <= entry_freq;
                        r_state   <= S_DIV1;
                    end else begin
                        // A rest keeps the period and the running flag.
                        r_duty  <= '0;
                        r_mode  <= pms_pkg::MODE_GAP;
                        r_state <= S_EMIT;
                    end
                end

                S_DIV1: begin
                    if (div_done) begin
                        r_period  <= n_period;
                        r_acc     <= '0;
                        r_mcand   <= pms_pkg::PROD_W'(n_period);
                        r_mplier  <= vol_eff;
                        r_mul_cnt <= '0;
                        r_state   <= S_MUL;
                    end
                end

                S_MUL: begin
                    // Shift-add over the volume bits, least significant first.
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_mul_cnt == MCNT_W'(pms_pkg::VOL_W - 1)) begin
                        r_state <= S_DIV2;
                    end else begin
                        r_mul_cnt <= r_mul_cnt + 1'b1;
                    end
                end

                S_DIV2: begin
                    if (!r_div_go && r_mul_cnt != '0) begin
                        r_div_go  <= 1'b1;
                        r_div_dvd <= DVD_W'(r_acc);
                        r_div_dsr <= pms_pkg::FREQ_W'(pms_pkg::PERCENT);
                        r_mul_cnt <= '0;
                    end else if (div_done) begin
                        r_duty  <= pms_pkg::DUTY_W'(div_quo);
                        r_state <= S_EMIT;
                    end
                end

                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_period  <= r_period;
                        r_out_duty    <= r_duty;
                        r_out_running <= r_running;
                        r_out_mode    <= r_mode;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reload_value  = r_out_period;
    assign o_compare_value = r_out_duty;
    assign o_pwm_running   = r_out_running;
    assign o_play_mode     = r_out_mode;

endmodule
